// ===== hw/rtl/dsos_pkg.sv =====
// Shared constants, register codes and types for the damped second-order smoother.
// No dependencies; compile first.
`timescale 1ns / 1ps

package dsos_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int MAX_CHANNELS_DEF   = 64;
	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int COEF_FRAC_BITS_DEF = 16;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHCOUNT = 2'd2;

	// Channel count register and channel field
	localparam int CHCNT_W = 7;
	localparam logic [CHCNT_W-1:0] CHCNT_RESET = 7'd64;
	localparam int CHAN_W = 6;

	// Warm-up phase codes
	localparam int WARM_W = 2;
	localparam logic [WARM_W-1:0] WARM_FILL_OLD = 2'd0;
	localparam logic [WARM_W-1:0] WARM_FILL_REC = 2'd1;
	localparam logic [WARM_W-1:0] WARM_DONE     = 2'd2;

	// Result buffer depth (covers the words in flight)
	localparam int OUT_DEPTH = 4;

	// History write enables
	typedef struct packed {
		logic old_we;
		logic rec_we;
	} hist_we_t;

endpackage

// ===== hw/rtl/dsos_sample_if.sv =====
// Input channel of the smoother: valid/ready plus sample and restart flag.
// Depends on dsos_pkg.
`timescale 1ns / 1ps

interface dsos_sample_if import dsos_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink   (input valid, input sample, input restart, output ready);
endinterface

// ===== hw/rtl/dsos_result_if.sv =====
// Output channel of the smoother: valid/ready plus filtered sample and frame info.
// Depends on dsos_pkg.
`timescale 1ns / 1ps

interface dsos_result_if import dsos_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] filtered;
	logic [CHAN_W-1:0]             channel;
	logic                          frame_end;
	logic                          settled;

	modport source (output valid, output filtered, output channel, output frame_end,
		output settled, input ready);
	modport sink   (input valid, input filtered, input channel, input frame_end,
		input settled, output ready);
endinterface

// ===== hw/rtl/damped_second_order_smoother_unit.sv =====
// Each accepted word passes stage 1 (history read) and stage 2 (sum and write-back).
// Throughput: one word per cycle while the buffer has room; two words in a row on one
// channel (one-channel frames, or channel 0 after a restart) wait while the first is
// in stage 1. The four-word result buffer reserves room for the words in flight.
// Reset clears channel position, warm-up, registers and pipeline; history memories
// are not cleared and are filled by the two warm-up frames.
`timescale 1ns / 1ps

module damped_second_order_smoother_unit import dsos_pkg::*; #(
	parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [COEF_FRAC_BITS:0]   cfg_data,
	dsos_sample_if.sink               samples,
	dsos_result_if.source             results
);

	localparam int S     = SAMPLE_BITS;
	localparam int F     = COEF_FRAC_BITS;
	localparam int PW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CW    = ($clog2(MAX_CHANNELS + 1) > CHCNT_W) ?
		$clog2(MAX_CHANNELS + 1) : CHCNT_W;
	localparam int OW    = S + CHAN_W + 2;
	localparam int OCW   = $clog2(OUT_DEPTH + 1);

	localparam logic [F:0]    COEF_ONE   = (F+1)'(1) << F;
	localparam logic [F:0]    ALPHA_RST  = (F+1)'(1) << (F - 2);
	localparam logic [F:0]    BETA_RST   = (F+1)'(3) << (F - 2);
	localparam logic [F+1:0]  COEF_TWO   = (F+2)'(1) << (F + 1);
	localparam logic [CW-1:0] CNT_MAX    = CW'(MAX_CHANNELS);

	// Configuration registers
	logic [F:0]         alpha_q;
	logic [F:0]         beta_q;
	logic [CHCNT_W-1:0] chcnt_q;

	// Derived coefficients
	logic [F:0]          a_clip;
	logic [F:0]          b_clip;
	logic [F:0]          coef_a_q;
	logic [F+1:0]        coef_c1_q;
	logic signed [F+1:0] coef_c2_q;

	// Frame control
	logic [PW-1:0]     position_q;
	logic [WARM_W-1:0] warm_q;
	logic [PW-1:0]     pos_in;
	logic [WARM_W-1:0] warm_in;
	logic [CW-1:0]     cnt_ext;
	logic [CW-1:0]     cnt_eff;
	logic              last_in;
	logic              hazard;
	logic              accept;
	logic [OCW-1:0]    occupancy;
	logic [OCW-1:0]    fifo_cnt;

	// Stage 1: history read returns
	logic              v_s1;
	logic signed [S-1:0] x_s1;
	logic [PW-1:0]     pos_s1;
	logic              last_s1;
	logic [WARM_W-1:0] warm_s1;
	logic [S-1:0]      rd_old;
	logic [S-1:0]      rd_rec;
	logic signed [S-1:0] y1_fwd;
	logic signed [S-1:0] y2_fwd;

	// Stage 2: sum and write back
	logic              v_s2;
	logic signed [S-1:0] x_s2;
	logic [PW-1:0]     pos_s2;
	logic              last_s2;
	logic [WARM_W-1:0] warm_s2;
	logic signed [S-1:0] y1_s2;
	logic signed [S-1:0] y_s2;
	logic              settled_s2;
	logic signed [S-1:0] filt_s2;
	hist_we_t          wr_en;
	logic [S-1:0]      wr_old;
	logic [S-1:0]      wr_rec;

	// Last write, registered for forwarding
	logic              wb_v_q;
	hist_we_t          wb_en_q;
	logic [PW-1:0]     wb_pos_q;
	logic [S-1:0]      wb_old_q;
	logic [S-1:0]      wb_rec_q;

	logic [OW-1:0]     push_data;
	logic [OW-1:0]     head_data;
	logic              head_valid;

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			beta_q  <= BETA_RST;
			chcnt_q <= CHCNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALPHA:   alpha_q <= cfg_data;
				CFG_BETA:    beta_q  <= cfg_data;
				CFG_CHCOUNT: chcnt_q <= cfg_data[CHCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clip coefficients to one and form the history weights
	assign a_clip = (alpha_q > COEF_ONE) ? COEF_ONE : alpha_q;
	assign b_clip = (beta_q > COEF_ONE) ? COEF_ONE : beta_q;

	always_ff @(posedge clk) begin
		coef_a_q  <= a_clip;
		coef_c1_q <= COEF_TWO - {1'b0, a_clip} - {1'b0, b_clip};
		coef_c2_q <= $signed({1'b0, b_clip}) - $signed({1'b0, COEF_ONE});
	end

	// Effective channel count: zero acts as one, clip to the memory depth
	assign cnt_ext = CW'(chcnt_q);
	always_comb begin
		if (cnt_ext == '0) begin
			cnt_eff = CW'(1);
		end else if (cnt_ext > CNT_MAX) begin
			cnt_eff = CNT_MAX;
		end else begin
			cnt_eff = cnt_ext;
		end
	end

	assign pos_in  = samples.restart ? '0 : position_q;
	assign warm_in = samples.restart ? WARM_FILL_OLD : warm_q;
	assign last_in = ((CW+1)'(pos_in) + (CW+1)'(1)) >= (CW+1)'(cnt_eff);

	// Hold off a word that may hit the channel still in stage 1
	assign hazard    = v_s1 && (pos_s1 == pos_in);
	assign occupancy = OCW'(v_s1) + OCW'(v_s2) + fifo_cnt;
	assign samples.ready = (occupancy < OCW'(OUT_DEPTH)) && !hazard;
	assign accept    = samples.valid && samples.ready;

	// Advance channel position and warm-up count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			warm_q     <= WARM_FILL_OLD;
		end else if (accept) begin
			if (last_in) begin
				position_q <= '0;
				if (warm_in == WARM_FILL_OLD || warm_in == WARM_FILL_REC) begin
					warm_q <= warm_in + WARM_W'(1);
				end else begin
					warm_q <= warm_in;
				end
			end else begin
				position_q <= pos_in + PW'(1);
				warm_q     <= warm_in;
			end
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			wb_v_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			wb_v_q <= v_s2;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		x_s1     <= samples.sample;
		pos_s1   <= pos_in;
		last_s1  <= last_in;
		warm_s1  <= warm_in;
		x_s2     <= x_s1;
		pos_s2   <= pos_s1;
		last_s2  <= last_s1;
		warm_s2  <= warm_s1;
		y1_s2    <= y1_fwd;
		wb_en_q  <= wr_en;
		wb_pos_q <= pos_s2;
		wb_old_q <= wr_old;
		wb_rec_q <= wr_rec;
	end

	dsos_hist #(
		.DEPTH (MAX_CHANNELS),
		.AW    (PW),
		.DW    (S)
	) u_hist (
		.clk     (clk),
		.rd_addr (pos_in),
		.rd_old  (rd_old),
		.rd_rec  (rd_rec),
		.wr_en   (wr_en),
		.wr_addr (pos_s2),
		.wr_old  (wr_old),
		.wr_rec  (wr_rec)
	);

	// Forward the write that landed on the read edge
	always_comb begin
		if (wb_v_q && wb_en_q.rec_we && (wb_pos_q == pos_s1)) begin
			y1_fwd = $signed(wb_rec_q);
		end else begin
			y1_fwd = $signed(rd_rec);
		end
		if (wb_v_q && wb_en_q.old_we && (wb_pos_q == pos_s1)) begin
			y2_fwd = $signed(wb_old_q);
		end else begin
			y2_fwd = $signed(rd_old);
		end
	end

	dsos_datapath #(
		.SAMPLE_BITS    (S),
		.COEF_FRAC_BITS (F)
	) u_datapath (
		.clk     (clk),
		.x_s1    (x_s1),
		.y1_s1   (y1_fwd),
		.y2_s1   (y2_fwd),
		.coef_a  (coef_a_q),
		.coef_c1 (coef_c1_q),
		.coef_c2 (coef_c2_q),
		.y_s2    (y_s2)
	);

	// Select result and history update by warm-up phase
	assign settled_s2 = warm_s2[1];
	assign filt_s2    = settled_s2 ? y_s2 : x_s2;

	always_comb begin
		wr_en.old_we = v_s2 && (warm_s2 != WARM_FILL_REC);
		wr_en.rec_we = v_s2 && (warm_s2 != WARM_FILL_OLD);
		wr_old       = settled_s2 ? y1_s2 : x_s2;
		wr_rec       = filt_s2;
	end

	assign push_data = {filt_s2, CHAN_W'(pos_s2), last_s2, settled_s2};

	dsos_out_fifo #(
		.W     (OW),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (v_s2),
		.push_data  (push_data),
		.pop        (results.valid && results.ready),
		.head_valid (head_valid),
		.head_data  (head_data),
		.count      (fifo_cnt)
	);

	assign results.valid     = head_valid;
	assign results.filtered  = $signed(head_data[OW-1 -: S]);
	assign results.channel   = head_data[CHAN_W+1:2];
	assign results.frame_end = head_data[1];
	assign results.settled   = head_data[0];

endmodule

// ===== hw/rtl/dsos_hist.sv =====
// Per-channel history store: older and recent output memories, registered read.
// Depends on dsos_pkg (hist_we_t).
`timescale 1ns / 1ps

module dsos_hist import dsos_pkg::*; #(
	parameter int DEPTH = MAX_CHANNELS_DEF,
	parameter int AW    = 6,
	parameter int DW    = SAMPLE_BITS_DEF
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_old,
	output logic [DW-1:0] rd_rec,
	input  hist_we_t      wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_old,
	input  logic [DW-1:0] wr_rec
);

	logic [DW-1:0] old_mem [DEPTH];
	logic [DW-1:0] rec_mem [DEPTH];

	// Read old contents on a same-address write; forwarding sits upstream
	always_ff @(posedge clk) begin
		rd_old <= old_mem[rd_addr];
		rd_rec <= rec_mem[rd_addr];
		if (wr_en.old_we) begin
			old_mem[wr_addr] <= wr_old;
		end
		if (wr_en.rec_we) begin
			rec_mem[wr_addr] <= wr_rec;
		end
	end

endmodule

// ===== hw/rtl/dsos_datapath.sv =====
// Filter arithmetic: three products registered, then sum, round and saturate.
// Depends on dsos_pkg for default sizes.
`timescale 1ns / 1ps

module dsos_datapath import dsos_pkg::*; #(
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic signed [SAMPLE_BITS-1:0]    x_s1,
	input  logic signed [SAMPLE_BITS-1:0]    y1_s1,
	input  logic signed [SAMPLE_BITS-1:0]    y2_s1,
	input  logic        [COEF_FRAC_BITS:0]   coef_a,
	input  logic        [COEF_FRAC_BITS+1:0] coef_c1,
	input  logic signed [COEF_FRAC_BITS+1:0] coef_c2,
	output logic signed [SAMPLE_BITS-1:0]    y_s2
);

	localparam int S     = SAMPLE_BITS;
	localparam int F     = COEF_FRAC_BITS;
	localparam int ACC_W = F + S + 3;
	localparam int Q_W   = S + 3;

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (F - 1);
	localparam logic signed [Q_W-1:0]   QMAX = $signed({4'b0000, {(S-1){1'b1}}});
	localparam logic signed [Q_W-1:0]   QMIN = $signed({4'b1111, {(S-1){1'b0}}});
	localparam logic signed [S-1:0]     YMAX = $signed({1'b0, {(S-1){1'b1}}});
	localparam logic signed [S-1:0]     YMIN = $signed({1'b1, {(S-1){1'b0}}});

	logic signed [F+S+1:0]  px;
	logic signed [F+S+2:0]  p1;
	logic signed [F+S+1:0]  p2;
	logic signed [F+S+1:0]  px_s2;
	logic signed [F+S+2:0]  p1_s2;
	logic signed [F+S+1:0]  p2_s2;
	logic signed [ACC_W-1:0] acc;
	logic signed [Q_W-1:0]   q;

	// Multiply each term by its coefficient
	assign px = $signed({1'b0, coef_a}) * x_s1;
	assign p1 = $signed({1'b0, coef_c1}) * y1_s1;
	assign p2 = coef_c2 * y2_s1;

	always_ff @(posedge clk) begin
		px_s2 <= px;
		p1_s2 <= p1;
		p2_s2 <= p2;
	end

	// Sum with half an LSB, then floor shift: round to nearest, ties up
	assign acc = ACC_W'(px_s2) + ACC_W'(p1_s2) + ACC_W'(p2_s2) + HALF;
	assign q   = acc[ACC_W-1:F];

	// Clip to the sample range
	always_comb begin
		if (q > QMAX) begin
			y_s2 = YMAX;
		end else if (q < QMIN) begin
			y_s2 = YMIN;
		end else begin
			y_s2 = q[S-1:0];
		end
	end

endmodule

// ===== hw/rtl/dsos_out_fifo.sv =====
// Result buffer between the pipeline and the output handshake.
// Depends on dsos_pkg for the default depth.
`timescale 1ns / 1ps

module dsos_out_fifo import dsos_pkg::*; #(
	parameter int W     = 24,
	parameter int DEPTH = OUT_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               push_data,
	input  logic                       pop,
	output logic                       head_valid,
	output logic [W-1:0]               head_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  buf_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	// Advance a pointer with wrap at the depth
	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + AW'(1);
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign head_valid = (cnt_q != '0);
	assign head_data  = buf_q[rd_ptr_q];
	assign count      = cnt_q;

endmodule

// ===== hw/rtl/dsos_checker.sv =====
// Port-level checks for the smoother top level, attached by bind.
// Depends on dsos_pkg and damped_second_order_smoother_unit.
`timescale 1ns / 1ps

module dsos_checker import dsos_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_filtered,
	input logic [CHAN_W-1:0]      out_channel,
	input logic                   out_frame_end,
	input logic                   out_settled
);

	// A stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_filtered) && $stable(out_channel)
			&& $stable(out_frame_end) && $stable(out_settled))
		else $error("result payload changed while stalled");

	// An empty output fills only from an input word that has passed stage 1 and stage 2
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 3))
		else $error("result word without a matching input word");

	// Nothing is offered right after reset
	a_out_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind damped_second_order_smoother_unit dsos_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_dsos_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (samples.valid),
	.in_ready      (samples.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.out_filtered  (results.filtered),
	.out_channel   (results.channel),
	.out_frame_end (results.frame_end),
	.out_settled   (results.settled)
);

// ===== test/tb.sv =====
// Self-checking bench for damped_second_order_smoother_unit: directed and random sample
// streams with a cycle-free model of the smoother checked against every result word.
// Depends on dsos_pkg, dsos_sample_if, dsos_result_if and the smoother RTL.
`timescale 1ns / 1ps

module tb;
	import dsos_pkg::*;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam int CF = COEF_FRAC_BITS_DEF;
	localparam int NCH = MAX_CHANNELS_DEF;
	localparam longint COEF_ONE = longint'(1) << CF;
	localparam longint SMAX = (longint'(1) << (SB - 1)) - 1;
	localparam longint SMIN = -SMAX - 1;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 48;
	localparam int DRAIN_CYCLES = 10;

	typedef logic signed [SB-1:0] sample_t;
	typedef logic [CF:0] coef_t;
	typedef logic [CHCNT_W-1:0] chcount_t;

	typedef struct packed {
		sample_t           filtered;
		logic [CHAN_W-1:0] channel;
		logic              frame_end;
		logic              settled;
	} smoothed_word_t;

	typedef enum {NO_PRESSURE, HOLD_OUTPUT, PAUSE_INPUT} pressure_t;

	// Mirror of the smoother: registers, per-channel history and the words it owes
	class smoother_mirror;
		coef_t             alpha_reg;
		coef_t             beta_reg;
		chcount_t          chan_count;
		sample_t           older_hist [NCH];
		sample_t           recent_hist [NCH];
		bit                older_seen [NCH];
		bit                recent_seen [NCH];
		logic [CHAN_W-1:0] position;
		logic [WARM_W-1:0] warm;
		smoothed_word_t    due_words [$];
		int                bad_words;
		int                words_checked;
		int                settled_words;

		function new();
			alpha_reg = coef_t'(COEF_ONE / 4);
			beta_reg = coef_t'(3 * COEF_ONE / 4);
			chan_count = CHCNT_RESET;
			position = '0;
			warm = WARM_FILL_OLD;
			bad_words = 0;
			words_checked = 0;
			settled_words = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, coef_t data);
			case (idx)
			CFG_ALPHA: alpha_reg = data;
			CFG_BETA: beta_reg = data;
			CFG_CHCOUNT: chan_count = data[CHCNT_W-1:0];
			default: ;
			endcase
		endfunction

		function int frame_size();
			if (chan_count == 0)
				return 1;
			if (chan_count > NCH)
				return NCH;
			return int'(chan_count);
		endfunction

		function int backlog();
			return due_words.size();
		endfunction

		// True when the next word, taken without restart, would filter on history
		// that was never written since reset
		function bit reads_unwritten();
			return warm == WARM_DONE && !(older_seen[position] && recent_seen[position]);
		endfunction

		function longint clamp_coef(coef_t c);
			return (c > COEF_ONE) ? COEF_ONE : longint'(c);
		endfunction

		// Advance the model by one accepted sample and queue the word it owes
		function void take_sample(sample_t x, logic restart);
			smoothed_word_t w;
			longint a;
			longint b;
			longint acc;
			bit last;
			if (restart) begin
				warm = WARM_FILL_OLD;
				position = '0;
			end
			last = (int'(position) + 1 >= frame_size());
			w.channel = position;
			w.frame_end = last;
			case (warm)
			WARM_FILL_OLD: begin
				older_hist[position] = x;
				older_seen[position] = 1'b1;
				w.filtered = x;
				w.settled = 1'b0;
			end
			WARM_FILL_REC: begin
				recent_hist[position] = x;
				recent_seen[position] = 1'b1;
				w.filtered = x;
				w.settled = 1'b0;
			end
			default: begin
				a = clamp_coef(alpha_reg);
				b = clamp_coef(beta_reg);
				acc = a * x + (2 * COEF_ONE - a - b) * recent_hist[position]
					+ (b - COEF_ONE) * older_hist[position];
				// half bias then floor: round to nearest, ties upward
				acc = (acc + COEF_ONE / 2) >>> CF;
				if (acc > SMAX)
					acc = SMAX;
				if (acc < SMIN)
					acc = SMIN;
				w.filtered = sample_t'(acc);
				w.settled = 1'b1;
				older_hist[position] = recent_hist[position];
				recent_hist[position] = w.filtered;
			end
			endcase
			due_words.push_back(w);
			if (last) begin
				position = '0;
				if (warm != WARM_DONE)
					warm = warm + 1'b1;
			end else begin
				position = position + 1'b1;
			end
		endfunction

		// Compare a delivered word with the oldest one owed
		function void match_word(smoothed_word_t got);
			smoothed_word_t want;
			if (due_words.size() == 0) begin
				bad_words++;
				$display("%0t: unexpected word filtered=%0d channel=%0d frame_end=%0b settled=%0b",
					$time, got.filtered, got.channel, got.frame_end, got.settled);
				return;
			end
			want = due_words.pop_front();
			words_checked++;
			if (want.settled)
				settled_words++;
			if (got !== want) begin
				bad_words++;
				$display("%0t: expected filtered=%0d channel=%0d frame_end=%0b settled=%0b",
					$time, want.filtered, want.channel, want.frame_end, want.settled);
				$display("%0t:   actual filtered=%0d channel=%0d frame_end=%0b settled=%0b",
					$time, got.filtered, got.channel, got.frame_end, got.settled);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	coef_t cfg_data;

	dsos_sample_if #(.SAMPLE_BITS(SB)) sample_ch ();
	dsos_result_if #(.SAMPLE_BITS(SB)) result_ch ();

	smoother_mirror mirror = new();

	int send_idle_pct = 11;
	int recv_idle_pct = 61;
	bit long_hold_req = 1'b0;
	int quiet = 0;
	int samples_fed = 0;
	int settings_used = 0;

	damped_second_order_smoother_unit #(
		.MAX_CHANNELS(NCH),
		.SAMPLE_BITS(SB),
		.COEF_FRAC_BITS(CF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.samples(sample_ch),
		.results(result_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sample both handshakes at the rising edge; count cycles where nothing moves
	always @(posedge clk) begin
		smoothed_word_t got;
		bit moved;
		if (arst_n === 1'b1) begin
			moved = 1'b0;
			if (sample_ch.valid && sample_ch.ready) begin
				mirror.take_sample(sample_ch.sample, sample_ch.restart);
				samples_fed++;
				moved = 1'b1;
			end
			if (result_ch.valid && result_ch.ready) begin
				got.filtered = result_ch.filtered;
				got.channel = result_ch.channel;
				got.frame_end = result_ch.frame_end;
				got.settled = result_ch.settled;
				mirror.match_word(got);
				moved = 1'b1;
			end
			quiet = moved ? 0 : quiet + 1;
		end else begin
			quiet = quiet + 1;
		end
	end

	// Result side: random back-pressure, plus one long hold on request
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				result_ch.ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 1'b0;
			end
			result_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Give up when no word moves for too long
	initial begin
		wait (quiet >= QUIET_LIMIT);
		$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	// Offer one word and hold it until taken; force restart rather than touch unwritten history
	task automatic send_word(input sample_t value, input logic restart_req);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_ch.valid = 1'b0;
			@(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.sample = value;
		sample_ch.restart = restart_req | mirror.reads_unwritten();
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering until every owed word has come back
	task automatic drain();
		sample_ch.valid = 1'b0;
		while (mirror.backlog() != 0)
			@(negedge clk);
	endtask

	// Write all three registers while the block is empty; junk in the unused count bits
	task automatic configure(input coef_t alpha, input coef_t beta, input chcount_t count);
		drain();
		cfg_we = 1'b1;
		cfg_index = CFG_ALPHA;
		cfg_data = alpha;
		mirror.write_reg(cfg_index, cfg_data);
		@(negedge clk);
		cfg_index = CFG_BETA;
		cfg_data = beta;
		mirror.write_reg(cfg_index, cfg_data);
		@(negedge clk);
		cfg_index = CFG_CHCOUNT;
		cfg_data = (coef_t'($urandom) & ~coef_t'(7'h7F)) | coef_t'(count);
		mirror.write_reg(cfg_index, cfg_data);
		@(negedge clk);
		cfg_we = 1'b0;
		settings_used++;
	endtask

	function automatic sample_t pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return sample_t'(SMAX);
		if (r < 16)
			return sample_t'(SMIN);
		if (r < 20)
			return '0;
		if (r < 24)
			return '1;
		if (r < 40)
			return sample_t'(int'($urandom_range(0, 200)) - 100);
		return sample_t'($urandom);
	endfunction

	// One register setting followed by a random stream with occasional restarts
	task automatic run_phase(input coef_t alpha, input coef_t beta, input chcount_t count,
		input int items, input int s_idle, input int r_idle, input pressure_t pressure);
		logic restart;
		configure(alpha, beta, count);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int i = 0; i < items; i++) begin
			restart = ($urandom_range(0, mirror.frame_size() * 8) == 0);
			if (pressure == HOLD_OUTPUT && i == 40)
				long_hold_req = 1'b1;
			if (pressure == PAUSE_INPUT && i == 100)
				drain();
			send_word(pick_sample(), restart);
		end
	endtask

	initial begin
		int a_rand;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ALPHA;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		sample_ch.restart = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Zero coefficients give y = 2*y1 - y2: drive both saturation rails
		configure('0, '0, 7'd2);
		send_word(sample_t'(SMAX), 1'b1);
		send_word(sample_t'(SMIN), 1'b0);
		send_word(sample_t'(SMIN), 1'b0);
		send_word(sample_t'(SMAX), 1'b0);
		send_word('0, 1'b0);
		send_word('0, 1'b0);
		send_word('1, 1'b0);
		send_word(sample_t'(1), 1'b0);
		send_word(sample_t'(12345), 1'b0);
		// restart in mid-frame, then warm up again
		send_word(sample_t'(-2), 1'b1);
		send_word(sample_t'(SMIN), 1'b0);
		send_word(sample_t'(SMAX), 1'b0);
		send_word(sample_t'(100), 1'b0);
		send_word(sample_t'(-100), 1'b0);
		// count lowered so the current position lies outside the frame; coefficients above one clamp
		configure(coef_t'(17'h1FFFF), coef_t'(COEF_ONE + 1), 7'd1);
		send_word(sample_t'(SMAX), 1'b0);
		send_word(sample_t'(SMIN), 1'b0);
		send_word('0, 1'b0);
		send_word('1, 1'b0);
		send_word(sample_t'(21845), 1'b0);
		send_word(sample_t'(-21846), 1'b0);

		// Sender mostly busy, receiver mostly stalled
		run_phase(coef_t'(COEF_ONE / 4), coef_t'(3 * COEF_ONE / 4), 7'd5, 180, 11, 61,
			NO_PRESSURE);
		run_phase(coef_t'(COEF_ONE / 2), coef_t'(COEF_ONE), 7'd3, 180, 11, 61, NO_PRESSURE);
		run_phase(coef_t'(COEF_ONE), '0, 7'd64, 260, 11, 61, HOLD_OUTPUT);

		// Sender mostly idle, receiver mostly ready
		run_phase(coef_t'(17'h1FFFF), coef_t'(17'h1FFFF), 7'd0, 150, 61, 11, NO_PRESSURE);
		a_rand = $urandom_range(0, int'(COEF_ONE));
		run_phase(coef_t'(a_rand),
			coef_t'(int'(2.0 * $sqrt(real'(a_rand) * real'(COEF_ONE))) - a_rand),
			7'd127, 260, 61, 11, PAUSE_INPUT);

		// No idling on either side
		run_phase(coef_t'($urandom), coef_t'($urandom), chcount_t'($urandom_range(1, 12)),
			180, 0, 0, NO_PRESSURE);
		run_phase(coef_t'(COEF_ONE / 16), coef_t'(7 * COEF_ONE / 16), 7'd7, 200, 0, 0,
			NO_PRESSURE);
		run_phase(coef_t'($urandom_range(0, int'(COEF_ONE))),
			coef_t'($urandom_range(0, int'(COEF_ONE))), 7'd2, 190, 0, 0, NO_PRESSURE);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d samples under %0d register settings", samples_fed, settings_used);
		$display("%0d words checked, %0d filtered, %0d failed, %0d still owed",
			mirror.words_checked, mirror.settled_words, mirror.bad_words, mirror.backlog());
		if (mirror.bad_words == 0 && mirror.backlog() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
